### src/utrbq_pkg.sv
// Package with the shared types and constants of the UART byte queue.
package utrbq_pkg;

  // Command codes carried by an input item.
  localparam logic [1:0] CMD_HOST_WRITE = 2'd0;
  localparam logic [1:0] CMD_TX_DONE    = 2'd1;
  localparam logic [1:0] CMD_RX_BYTE    = 2'd2;
  localparam logic [1:0] CMD_HOST_READ  = 2'd3;

  // A received byte with this value is a halt request and is never stored.
  localparam logic [7:0] HALT_CHAR = 8'd4;

  // One input item.
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } request_t;

  // One result item.
  typedef struct packed {
    logic       write_accepted;
    logic       tx_start;
    logic [7:0] tx_byte;
    logic       tx_stop;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       halt_request;
    logic       rx_overflow;
    logic [7:0] tx_level;
    logic [6:0] rx_level;
  } result_t;

  // Operations requested of a queue in one cycle.
  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  // Status reported by a queue.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

### src/utrbq_queue.sv
// Byte queue built around one synchronous memory with a registered read port.
module utrbq_queue
  import utrbq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  queue_ctrl_t                ctrl,
  input  logic [7:0]                 wdata,
  output logic [7:0]                 rdata,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output queue_stat_t                stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_INDEX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] tail;

  // Store a pushed byte at the tail.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail] <= wdata;
    end
  end

  // A pop reads the head entry; the byte is available in the cycle after the pop.
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      rdata <= mem[head];
    end
  end

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctrl.push) begin
        tail <= (tail == LAST_INDEX) ? '0 : tail + 1'b1;
      end
      if (ctrl.pop) begin
        head <= (head == LAST_INDEX) ? '0 : head + 1'b1;
      end
      if (ctrl.push && !ctrl.pop) begin
        count <= count + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == FULL_COUNT);

endmodule

### src/uart_tx_rx_byte_queue.sv
// Top level of the UART byte queue: command decode, transmitter state and result register.
//
// Usage: a command item (request) is taken at a rising edge where start is high
// and busy is low. busy is always low, so a command may be issued every cycle.
// Commands are a host write, a transmit-done event, a received byte and a host
// read. Each command gives exactly one result on the result port, marked by
// done for one cycle, in the cycle right after it was taken (throughput one
// command per cycle). The result is registered to match the registered read
// port of the queue memories: a popped byte leaves the memory in the cycle after
// the pop. Levels report the queue fill after the command.
// The transmit queue and the receive queue each live in their own memory; at
// most one of them is touched per command, so no read can collide with a write
// to the same entry within one command.
// Reset (rst, synchronous) empties both queues by clearing their pointers and
// counts, marks the transmitter idle and drops any pending result; memory
// contents are not cleared. The receiver of results cannot stall: a result is
// transferred at the edge that ends its done cycle.
module uart_tx_rx_byte_queue
  import utrbq_pkg::*;
#(
  parameter int TX_DEPTH = 128,
  parameter int RX_DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  localparam int TX_CW = $clog2(TX_DEPTH + 1);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);

  queue_ctrl_t      tx_ctrl;
  queue_stat_t      tx_stat;
  logic [7:0]       tx_rdata;
  logic [TX_CW-1:0] tx_count;
  queue_ctrl_t      rx_ctrl;
  queue_stat_t      rx_stat;
  logic [7:0]       rx_rdata;
  logic [RX_CW-1:0] rx_count;

  logic tx_busy;
  logic tx_busy_next;

  // Flags decoded for the current command.
  logic accepted_next;
  logic start_next;
  logic from_queue_next;
  logic stop_next;
  logic rvalid_next;
  logic halt_next;
  logic ovf_next;

  // Registered result flags.
  logic       accepted;
  logic       tx_go;
  logic       from_queue;
  logic       stop;
  logic       rvalid;
  logic       halt;
  logic       ovf;
  logic [7:0] direct_byte;

  logic [15:0] tx_count_wide;
  logic [15:0] rx_count_wide;

  // No command ever stalls, so a new one is always welcome.
  assign busy = 1'b0;

  utrbq_queue #(
    .DEPTH(TX_DEPTH)
  ) u_tx_queue (
    .clk  (clk),
    .rst  (rst),
    .ctrl (tx_ctrl),
    .wdata(request.data_byte),
    .rdata(tx_rdata),
    .count(tx_count),
    .stat (tx_stat)
  );

  utrbq_queue #(
    .DEPTH(RX_DEPTH)
  ) u_rx_queue (
    .clk  (clk),
    .rst  (rst),
    .ctrl (rx_ctrl),
    .wdata(request.data_byte),
    .rdata(rx_rdata),
    .count(rx_count),
    .stat (rx_stat)
  );

  // Decode the command against the queue status and the transmitter state.
  always_comb begin
    tx_ctrl         = '0;
    rx_ctrl         = '0;
    tx_busy_next    = tx_busy;
    accepted_next   = 1'b0;
    start_next      = 1'b0;
    from_queue_next = 1'b0;
    stop_next       = 1'b0;
    rvalid_next     = 1'b0;
    halt_next       = 1'b0;
    ovf_next        = 1'b0;
    if (start) begin
      unique case (request.command)
        CMD_HOST_WRITE: begin
          if (!tx_busy) begin
            tx_busy_next  = 1'b1;
            accepted_next = 1'b1;
            start_next    = 1'b1;
          end else if (!tx_stat.full) begin
            tx_ctrl.push  = 1'b1;
            accepted_next = 1'b1;
          end
        end
        CMD_TX_DONE: begin
          if (tx_busy) begin
            if (tx_stat.empty) begin
              tx_busy_next = 1'b0;
              stop_next    = 1'b1;
            end else begin
              tx_ctrl.pop     = 1'b1;
              start_next      = 1'b1;
              from_queue_next = 1'b1;
            end
          end
        end
        CMD_RX_BYTE: begin
          if (request.data_byte == HALT_CHAR) begin
            halt_next = 1'b1;
          end else if (rx_stat.full) begin
            ovf_next = 1'b1;
          end else begin
            rx_ctrl.push = 1'b1;
          end
        end
        CMD_HOST_READ: begin
          if (!rx_stat.empty) begin
            rx_ctrl.pop = 1'b1;
            rvalid_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state and result flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_busy    <= 1'b0;
      done       <= 1'b0;
      accepted   <= 1'b0;
      tx_go      <= 1'b0;
      from_queue <= 1'b0;
      stop       <= 1'b0;
      rvalid     <= 1'b0;
      halt       <= 1'b0;
      ovf        <= 1'b0;
    end else begin
      tx_busy    <= tx_busy_next;
      done       <= start;
      accepted   <= accepted_next;
      tx_go      <= start_next;
      from_queue <= from_queue_next;
      stop       <= stop_next;
      rvalid     <= rvalid_next;
      halt       <= halt_next;
      ovf        <= ovf_next;
    end
  end

  // The byte that bypasses the queue on a write to an idle transmitter.
  always_ff @(posedge clk) begin
    if (start) begin
      direct_byte <= request.data_byte;
    end
  end

  // Levels are reported modulo the width of their fields.
  assign tx_count_wide = 16'(tx_count);
  assign rx_count_wide = 16'(rx_count);

  // Assemble the result from the flags, the memory read ports and the counts.
  always_comb begin
    result.write_accepted = accepted;
    result.tx_start       = tx_go;
    result.tx_byte        = tx_go ? (from_queue ? tx_rdata : direct_byte) : 8'd0;
    result.tx_stop        = stop;
    result.read_valid     = rvalid;
    result.read_byte      = rvalid ? rx_rdata : 8'd0;
    result.halt_request   = halt;
    result.rx_overflow    = ovf;
    result.tx_level       = tx_count_wide[7:0];
    result.rx_level       = rx_count_wide[6:0];
  end

endmodule
